FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication form, checked from the same edge.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Implication form, checked at the next edge.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dmsc_pkg.sv
// Package: constants, register indexes and the job type of the demosaic.
`timescale 1ns / 1ps
`default_nettype none
package dmsc_pkg;
    localparam int DATA_W        = 16;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int HEIGHT_LIMIT  = 16384;
    localparam int ROW_W         = 14;
    localparam int DIM_W         = 15;
    localparam int Q_DEPTH       = 4;
    localparam int PADDR_W       = 4;

    localparam logic [12:0] WIDTH_RST  = 13'd640;
    localparam logic [14:0] HEIGHT_RST = 15'd480;
    localparam logic [1:0]  PHASE_RST  = 2'd0;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CFA_PHASE    = 2'd2;

    // One output pixel to compute: window snapshot plus neighbor flags.
    typedef struct packed {
        logic [8:0][DATA_W-1:0] win;
        logic cr2;
        logic cc2;
        logic up;
        logic dn;
        logic lf;
        logic rt;
        logic xr;
        logic yr;
        logic fend;
        logic last;
    } t_job;
endpackage
`default_nettype wire

FILE: hw/rtl/dmsc_if.sv
// Valid/ready channel interfaces for raw pixels and RGB results.
`timescale 1ns / 1ps
`default_nettype none
interface dmsc_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_pixel;
    modport source (output valid, output raw_pixel, input ready);
    modport sink   (input valid, input raw_pixel, output ready);
endinterface

interface dmsc_rgb_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last_of_run;
    logic        frame_end;
    modport source (output valid, output red, output green, output blue,
                    output last_of_run, output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_of_run, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/dmsc_front.sv
// Front end: line stores, 3x3 window, raster counters and job generation.
`timescale 1ns / 1ps
`default_nettype none
module dmsc_front #(
    parameter int MAX_WIDTH = dmsc_pkg::MAX_WIDTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    dmsc_pix_if.sink          i_pix,
    input  wire  [12:0]       i_frame_width,
    input  wire  [14:0]       i_frame_height,
    input  wire  [1:0]        i_cfa_phase,
    input  wire               i_full,
    output logic              o_push,
    output dmsc_pkg::t_job    o_job
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = dmsc_pkg::DATA_W;
    localparam int RW = dmsc_pkg::ROW_W;
    localparam int NW = dmsc_pkg::DIM_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_UPD  = 3'b010,
        S_EMIT = 3'b100
    } t_front_state;

    t_front_state r_state;
    logic [DW-1:0] r_raw;
    logic [AW-1:0] r_x;
    logic [RW-1:0] r_y;
    logic [8:0][DW-1:0] r_win;
    logic [3:0] r_mask;
    logic r_row_end;
    logic r_last_row;
    logic [DW-1:0] r_old_rd;
    logic [DW-1:0] r_prev_rd;
    logic [DW-1:0] older_line [MAX_WIDTH];
    logic [DW-1:0] previous_line [MAX_WIDTH];

    logic [NW-1:0] w_use;
    logic [NW-1:0] h_use;
    logic row_end;
    logic last_row;
    logic accept;
    logic [1:0] k;
    logic [3:0] n_mask;
    logic done;

    always_comb begin
        if (i_frame_width < 13'd3) begin
            w_use = NW'(3);
        end else if ({2'b00, i_frame_width} > NW'(MAX_WIDTH)) begin
            w_use = NW'(MAX_WIDTH);
        end else begin
            w_use = {2'b00, i_frame_width};
        end
        if (i_frame_height < 15'd3) begin
            h_use = NW'(3);
        end else if (i_frame_height > NW'(dmsc_pkg::HEIGHT_LIMIT)) begin
            h_use = NW'(dmsc_pkg::HEIGHT_LIMIT);
        end else begin
            h_use = i_frame_height;
        end
    end

    assign row_end  = NW'(r_x) >= (w_use - NW'(1));
    assign last_row = NW'(r_y) >= (h_use - NW'(1));
    assign i_pix.ready = (r_state == S_IDLE);
    assign accept = i_pix.valid && i_pix.ready;

    // lowest pending job, in emission order
    always_comb begin
        if (r_mask[0]) begin
            k = 2'd0;
        end else if (r_mask[1]) begin
            k = 2'd1;
        end else if (r_mask[2]) begin
            k = 2'd2;
        end else begin
            k = 2'd3;
        end
        n_mask = r_mask & ~(4'b0001 << k);
    end

    always_comb begin
        o_job.win  = r_win;
        o_job.cr2  = k[0];
        o_job.cc2  = k[1];
        o_job.up   = k[0] ? 1'b1 : (r_y > RW'(1));
        o_job.dn   = ~k[0];
        o_job.lf   = k[1] ? 1'b1 : (r_x > AW'(1));
        o_job.rt   = ~k[1];
        o_job.xr   = (k[1] ? r_x[0] : ~r_x[0]) == i_cfa_phase[0];
        o_job.yr   = (k[0] ? r_y[0] : ~r_y[0]) == i_cfa_phase[1];
        o_job.fend = (k == 2'd3);
        o_job.last = (n_mask == 4'd0);
    end

    assign o_push = (r_state == S_EMIT) && (r_mask != 4'd0) && !i_full;
    assign done   = (r_state == S_EMIT) && ((r_mask == 4'd0) || (o_push && o_job.last));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw     <= i_pix.raw_pixel;
            r_old_rd  <= older_line[r_x];
            r_prev_rd <= previous_line[r_x];
        end
        if (r_state == S_UPD) begin
            older_line[r_x]    <= r_prev_rd;
            previous_line[r_x] <= r_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_x        <= '0;
            r_y        <= '0;
            r_win      <= '0;
            r_mask     <= '0;
            r_row_end  <= 1'b0;
            r_last_row <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_row_end  <= row_end;
                        r_last_row <= last_row;
                        r_state    <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= r_old_rd;
                    r_win[3] <= r_win[4];
                    r_win[4] <= r_win[5];
                    r_win[5] <= r_prev_rd;
                    r_win[6] <= r_win[7];
                    r_win[7] <= r_win[8];
                    r_win[8] <= r_raw;
                    if (r_y != '0) begin
                        r_mask <= {r_row_end & r_last_row, r_row_end,
                                   (r_x != '0) & r_last_row, r_x != '0};
                    end else begin
                        r_mask <= 4'd0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_push) begin
                        r_mask <= n_mask;
                    end
                    if (done) begin
                        if (r_row_end) begin
                            r_x <= '0;
                            r_y <= r_last_row ? '0 : r_y + RW'(1);
                        end else begin
                            r_x <= r_x + AW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/dmsc_queue.sv
// Short job queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module dmsc_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  dmsc_pkg::t_job  i_job,
    output logic            o_full,
    input  wire             i_pop,
    output dmsc_pkg::t_job  o_job,
    output logic            o_empty
);
    localparam int D  = dmsc_pkg::Q_DEPTH;
    localparam int PW = $clog2(D);

    dmsc_pkg::t_job r_mem [D];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(D));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/dmsc_back.sv
// Back end: neighbor sums, rounded means and the output register.
`timescale 1ns / 1ps
`default_nettype none
module dmsc_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  dmsc_pkg::t_job  i_job,
    input  wire             i_empty,
    output logic            o_pop,
    dmsc_rgb_if.source      o_rgb
);
    localparam int DW = dmsc_pkg::DATA_W;
    localparam int SW = DW + 2;

    // round(s/3) = floor((s+1) * ceil(2^19/3) / 2^19), exact for s below 2^18
    localparam logic [SW-1:0] RECIP3 = SW'(174763);

    function automatic logic [DW-1:0] win_px(input logic [8:0][DW-1:0] win,
                                             input logic [1:0] r, input logic [1:0] c);
        logic [3:0] idx;
        idx = 4'(r) * 4'd3 + 4'(c);
        if (idx > 4'd8) begin
            idx = 4'd0;
        end
        return win[idx];
    endfunction

    function automatic logic [DW-1:0] mean(input logic [SW-1:0] s, input logic [2:0] n);
        logic [SW:0]     s1;
        logic [SW-1:0]   s2;
        logic [2*SW:0]   prod;
        logic [DW-1:0]   res;
        s1   = {1'b0, s} + (SW+1)'(1);
        s2   = s + SW'(2);
        prod = (2*SW+1)'(s1) * (2*SW+1)'(RECIP3);
        case (n)
            3'd1:    res = s[DW-1:0];
            3'd2:    res = s1[DW:1];
            3'd3:    res = prod[19 +: DW];
            3'd4:    res = s2[DW+1:2];
            default: res = '0;
        endcase
        return res;
    endfunction

    logic r_a_valid;
    logic [2:0][SW-1:0] r_a_sum;
    logic [2:0][2:0]    r_a_cnt;
    logic r_a_fend;
    logic r_a_last;
    logic r_o_valid;
    logic [DW-1:0] r_red;
    logic [DW-1:0] r_grn;
    logic [DW-1:0] r_blu;
    logic r_o_fend;
    logic r_o_last;

    logic out_free;
    logic [1:0] r;
    logic [1:0] c;
    logic [SW-1:0] own;
    logic [SW-1:0] hs;
    logic [SW-1:0] vs;
    logic [SW-1:0] ds;
    logic [2:0] hc;
    logic [2:0] vc;
    logic [2:0] dc;
    logic [2:0][SW-1:0] n_sum;
    logic [2:0][2:0]    n_cnt;

    assign out_free = !r_o_valid || o_rgb.ready;
    assign o_pop    = !i_empty && (!r_a_valid || out_free);

    always_comb begin
        r   = 2'd1 + 2'(i_job.cr2);
        c   = 2'd1 + 2'(i_job.cc2);
        own = SW'(win_px(i_job.win, r, c));
        hs = '0; vs = '0; ds = '0;
        hc = '0; vc = '0; dc = '0;
        if (i_job.lf) begin hs = hs + SW'(win_px(i_job.win, r, c - 2'd1)); hc = hc + 3'd1; end
        if (i_job.rt) begin hs = hs + SW'(win_px(i_job.win, r, c + 2'd1)); hc = hc + 3'd1; end
        if (i_job.up) begin vs = vs + SW'(win_px(i_job.win, r - 2'd1, c)); vc = vc + 3'd1; end
        if (i_job.dn) begin vs = vs + SW'(win_px(i_job.win, r + 2'd1, c)); vc = vc + 3'd1; end
        if (i_job.up && i_job.lf) begin
            ds = ds + SW'(win_px(i_job.win, r - 2'd1, c - 2'd1)); dc = dc + 3'd1;
        end
        if (i_job.up && i_job.rt) begin
            ds = ds + SW'(win_px(i_job.win, r - 2'd1, c + 2'd1)); dc = dc + 3'd1;
        end
        if (i_job.dn && i_job.lf) begin
            ds = ds + SW'(win_px(i_job.win, r + 2'd1, c - 2'd1)); dc = dc + 3'd1;
        end
        if (i_job.dn && i_job.rt) begin
            ds = ds + SW'(win_px(i_job.win, r + 2'd1, c + 2'd1)); dc = dc + 3'd1;
        end
        // index 0 red, 1 green, 2 blue; own color is a mean over one value
        if (i_job.xr && i_job.yr) begin
            n_sum = {ds, hs + vs, own};
            n_cnt = {dc, hc + vc, 3'd1};
        end else if (!i_job.xr && !i_job.yr) begin
            n_sum = {own, hs + vs, ds};
            n_cnt = {3'd1, hc + vc, dc};
        end else if (i_job.yr) begin
            n_sum = {vs, own, hs};
            n_cnt = {vc, 3'd1, hc};
        end else begin
            n_sum = {hs, own, vs};
            n_cnt = {hc, 3'd1, vc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_sum  <= n_sum;
            r_a_cnt  <= n_cnt;
            r_a_fend <= i_job.fend;
            r_a_last <= i_job.last;
        end
        if (r_a_valid && out_free) begin
            r_red    <= mean(r_a_sum[0], r_a_cnt[0]);
            r_grn    <= mean(r_a_sum[1], r_a_cnt[1]);
            r_blu    <= mean(r_a_sum[2], r_a_cnt[2]);
            r_o_fend <= r_a_fend;
            r_o_last <= r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_a_valid <= 1'b1;
            end else if (out_free) begin
                r_a_valid <= 1'b0;
            end
            if (out_free) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    assign o_rgb.valid       = r_o_valid;
    assign o_rgb.red         = r_red;
    assign o_rgb.green       = r_grn;
    assign o_rgb.blue        = r_blu;
    assign o_rgb.frame_end   = r_o_fend;
    assign o_rgb.last_of_run = r_o_last;
endmodule
`default_nettype wire

FILE: hw/rtl/bayer_bilinear_demosaic.sv
// Top level: bilinear Bayer demosaic with APB register port.
// An item passes the front end as accept, window update, then one queue push per result.
// The front end takes no new item until its last push is made; pushes wait while the queue is full.
// Each result then passes the queue and two back stages (sums, output register).
// Synchronous active-low reset clears counters, window, queue and registers; line stores keep data.
`timescale 1ns / 1ps
`default_nettype none
module bayer_bilinear_demosaic #(
    parameter int MAX_WIDTH = dmsc_pkg::MAX_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    dmsc_pix_if.sink                      i_pix,
    dmsc_rgb_if.source                    o_rgb,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [dmsc_pkg::PADDR_W-1:0]  paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    logic [12:0] r_frame_width;
    logic [14:0] r_frame_height;
    logic [1:0]  r_cfa_phase;
    logic        wr;

    dmsc_pkg::t_job f_job;
    dmsc_pkg::t_job q_job;
    logic push;
    logic full;
    logic pop;
    logic empty;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= dmsc_pkg::WIDTH_RST;
            r_frame_height <= dmsc_pkg::HEIGHT_RST;
            r_cfa_phase    <= dmsc_pkg::PHASE_RST;
        end else if (wr) begin
            case (paddr[3:2])
                dmsc_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[12:0];
                dmsc_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[14:0];
                dmsc_pkg::REG_CFA_PHASE:    r_cfa_phase    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dmsc_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, r_frame_width};
            dmsc_pkg::REG_FRAME_HEIGHT: prdata = {17'd0, r_frame_height};
            dmsc_pkg::REG_CFA_PHASE:    prdata = {30'd0, r_cfa_phase};
            default:                    prdata = '0;
        endcase
    end

    dmsc_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (i_pix),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_cfa_phase    (r_cfa_phase),
        .i_full         (full),
        .o_push         (push),
        .o_job          (f_job)
    );

    dmsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_empty (empty)
    );

    dmsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_rgb   (o_rgb)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/dmsc_checker.sv
// Port-level checker for the demosaic, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dmsc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [15:0] i_red,
    input wire [15:0] i_green,
    input wire [15:0] i_blue,
    input wire        i_last,
    input wire        i_fend
);
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_red) && $stable(i_green) && $stable(i_blue) && $stable(i_fend) && $stable(i_last), "stalled result changed")
    `ASSERT_IMP(a_fend_last, i_clk, i_rst_n, i_out_valid && i_fend, i_last, "frame end not last of run")
    `ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "item accepted back to back")
endmodule

bind bayer_bilinear_demosaic dmsc_checker u_dmsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue),
    .i_last      (o_rgb.last_of_run),
    .i_fend      (o_rgb.frame_end)
);
`default_nettype wire

FILE: verif/bayer_bilinear_demosaic_tb.sv
// Testbench: random-stall stream check of the bilinear demosaic against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module bayer_bilinear_demosaic_tb;
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last;
        logic        fend;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [dmsc_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dmsc_pix_if pix ();
    dmsc_rgb_if rgb ();

    bayer_bilinear_demosaic dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix), .o_rgb(rgb),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [12:0] cur_width = dmsc_pkg::WIDTH_RST;
    logic [14:0] cur_height = dmsc_pkg::HEIGHT_RST;
    logic [1:0]  cur_phase = dmsc_pkg::PHASE_RST;
    logic [15:0] older_row [dmsc_pkg::MAX_WIDTH_DEF];
    logic [15:0] prev_row [dmsc_pkg::MAX_WIDTH_DEF];
    logic [15:0] win [9];
    int          col_cnt = 0;
    int          row_cnt = 0;

    logic [15:0] raw_queue [$];
    t_rgb        rgb_pending [$];
    int          errors = 0;
    bit          quiet = 0;

    function automatic logic [15:0] avg(int s, int c);
        return (c == 0) ? 16'd0 : 16'((s + c / 2) / c);
    endfunction

    function automatic logic [15:0] win_px(int r, int c);
        return win[(r * 3 + c) % 9];
    endfunction

    function automatic t_rgb interp(int r, int c, int x, int y,
                                    bit up, bit dn, bit lf, bit rt, bit fe);
        int hs, hc, vs, vc, ds, dc;
        bit xr, yr;
        t_rgb o;
        hs = 0; hc = 0; vs = 0; vc = 0; ds = 0; dc = 0;
        xr = (x[0] == cur_phase[0]);
        yr = (y[0] == cur_phase[1]);
        if (lf) begin hs += win_px(r, c - 1); hc++; end
        if (rt) begin hs += win_px(r, c + 1); hc++; end
        if (up) begin vs += win_px(r - 1, c); vc++; end
        if (dn) begin vs += win_px(r + 1, c); vc++; end
        if (up && lf) begin ds += win_px(r - 1, c - 1); dc++; end
        if (up && rt) begin ds += win_px(r - 1, c + 1); dc++; end
        if (dn && lf) begin ds += win_px(r + 1, c - 1); dc++; end
        if (dn && rt) begin ds += win_px(r + 1, c + 1); dc++; end
        if (xr && yr) begin
            o.red = win_px(r, c); o.green = avg(hs + vs, hc + vc); o.blue = avg(ds, dc);
        end else if (!xr && !yr) begin
            o.blue = win_px(r, c); o.green = avg(hs + vs, hc + vc); o.red = avg(ds, dc);
        end else if (yr) begin
            // green on a red row
            o.green = win_px(r, c); o.red = avg(hs, hc); o.blue = avg(vs, vc);
        end else begin
            o.green = win_px(r, c); o.blue = avg(hs, hc); o.red = avg(vs, vc);
        end
        o.last = 1'b0;
        o.fend = fe;
        return o;
    endfunction

    task automatic demosaic_step(input logic [15:0] raw);
        int w, h, x, y, ix, n;
        bit row_end, last_row;
        w = cur_width; h = cur_height;
        x = col_cnt; y = row_cnt;
        ix = (x < dmsc_pkg::MAX_WIDTH_DEF) ? x : 0;
        n = 0;
        if (w < 3) w = 3;
        if (w > dmsc_pkg::MAX_WIDTH_DEF) w = dmsc_pkg::MAX_WIDTH_DEF;
        if (h < 3) h = 3;
        if (h > dmsc_pkg::HEIGHT_LIMIT) h = dmsc_pkg::HEIGHT_LIMIT;
        row_end = x >= w - 1;
        last_row = y >= h - 1;
        for (int r = 0; r < 3; r++) begin
            win[r * 3] = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = older_row[ix];
        win[5] = prev_row[ix];
        win[8] = raw;
        older_row[ix] = prev_row[ix];
        prev_row[ix] = raw;
        if (y >= 1) begin
            if (x >= 1) begin
                rgb_pending.push_back(interp(1, 1, x - 1, y - 1, y > 1, 1, x > 1, 1, 0));
                n++;
                if (last_row) begin
                    rgb_pending.push_back(interp(2, 1, x - 1, y, 1, 0, x > 1, 1, 0));
                    n++;
                end
            end
            if (row_end) begin
                rgb_pending.push_back(interp(1, 2, x, y - 1, y > 1, 1, 1, 0, 0));
                n++;
                if (last_row) begin
                    rgb_pending.push_back(interp(2, 2, x, y, 1, 0, 1, 0, 1));
                    n++;
                end
            end
        end
        if (n > 0) rgb_pending[rgb_pending.size() - 1].last = 1'b1;
        if (row_end) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : y + 1;
        end else begin
            col_cnt = x + 1;
        end
    endtask

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else begin
            if (pix.valid && pix.ready) demosaic_step(pix.raw_pixel);
            if (!pix.valid || pix.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pix.valid <= 1'b0;
                end else if (raw_queue.size() > 0) begin
                    pix.valid <= 1'b1;
                    pix.raw_pixel <= raw_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = (quiet || $urandom_range(0, 3) == 0) ? 0
                                   : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: alternates free-running stretches with random stalls
    int stall_mode = 0;
    int mode_cycles = 0;
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_cycles = $urandom_range(16, 96);
        end else begin
            mode_cycles--;
        end
        case (stall_mode)
            0: rgb.ready <= 1'b1;
            1: rgb.ready <= ($urandom_range(0, 1) == 1);
            default: rgb.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && rgb.valid && rgb.ready) begin
            if (rgb_pending.size() == 0) begin
                report("result with none expected");
            end else begin
                want = rgb_pending.pop_front();
                if (rgb.red !== want.red)
                    report($sformatf("red %h want %h", rgb.red, want.red));
                if (rgb.green !== want.green)
                    report($sformatf("green %h want %h", rgb.green, want.green));
                if (rgb.blue !== want.blue)
                    report($sformatf("blue %h want %h", rgb.blue, want.blue));
                if (rgb.last_of_run !== want.last)
                    report($sformatf("last_of_run %b want %b", rgb.last_of_run, want.last));
                if (rgb.frame_end !== want.fend)
                    report($sformatf("frame_end %b want %b", rgb.frame_end, want.fend));
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input int val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            dmsc_pkg::REG_FRAME_WIDTH:  cur_width = val[12:0];
            dmsc_pkg::REG_FRAME_HEIGHT: cur_height = val[14:0];
            dmsc_pkg::REG_CFA_PHASE:    cur_phase = val[1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (raw_queue.size() != 0 || pix.valid || rgb_pending.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // write the frame registers while idle, then queue a frame
    task automatic frame(input int w, input int h, input int ph, input int cnt,
                         input bit pause_mid);
        int eff_w, eff_h;
        drain();
        repeat (12) @(posedge i_clk);  // row 0 items make no results
        reg_write(dmsc_pkg::REG_FRAME_WIDTH, w);
        reg_write(dmsc_pkg::REG_FRAME_HEIGHT, h);
        reg_write(dmsc_pkg::REG_CFA_PHASE, ph);
        eff_w = (w < 3) ? 3 : (w > dmsc_pkg::MAX_WIDTH_DEF) ? dmsc_pkg::MAX_WIDTH_DEF : w;
        eff_h = (h < 3) ? 3 : (h > dmsc_pkg::HEIGHT_LIMIT) ? dmsc_pkg::HEIGHT_LIMIT : h;
        cnt = eff_w * eff_h;
        for (int i = 0; i < cnt; i++) begin
            if (pause_mid && i == cnt / 2) drain();
            raw_queue.push_back(rand_pixel());
        end
    endtask

    initial begin
        logic [15:0] edge_vals [9];
        int total;
        int w, h;
        i_rst_n = 1'b0;
        pix.valid = 1'b0;
        pix.raw_pixel = '0;
        rgb.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest frame with extreme values
        edge_vals = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                      16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        drain();
        reg_write(dmsc_pkg::REG_FRAME_WIDTH, 3);
        reg_write(dmsc_pkg::REG_FRAME_HEIGHT, 3);
        reg_write(dmsc_pkg::REG_CFA_PHASE, 0);
        foreach (edge_vals[i]) raw_queue.push_back(edge_vals[i]);
        // 4x4, bit patterns, BGGR; odd rounding on sums
        drain();
        repeat (12) @(posedge i_clk);
        reg_write(dmsc_pkg::REG_FRAME_WIDTH, 4);
        reg_write(dmsc_pkg::REG_FRAME_HEIGHT, 4);
        reg_write(dmsc_pkg::REG_CFA_PHASE, 3);
        for (int i = 0; i < 16; i++)
            raw_queue.push_back(i[0] ? 16'hAAAA : (i[1] ? 16'h5555 : 16'hFFFE));

        // undersized frames clamp to 3x3
        quiet = 1;
        frame(2, 1, 1, 0, 0);
        frame(0, 0, 2, 0, 0);
        quiet = 0;

        total = 0;
        while (total < 330) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            frame(w, h, $urandom_range(0, 3), 0, total == 0);
            total += ((w < 3) ? 3 : w) * ((h < 3) ? 3 : h);
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(64'd8_000_000);
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
